### hw/rtl/sorted_sparse_vector_accumulator_assert.svh
// Assertion macros for the sparse vector accumulator.
// Each expects clk and rst_n in scope.
`ifndef SORTED_SPARSE_VECTOR_ACCUMULATOR_ASSERT_SVH
`define SORTED_SPARSE_VECTOR_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication.
`define SSVA_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("ssva assertion failed");

// Next-cycle implication.
`define SSVA_ASSERT_NXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("ssva assertion failed");

`endif

### hw/rtl/ssva_pkg.sv
`timescale 1ns / 1ps

package ssva_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int TOT_W    = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_ACCUM  = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_REMOVED = 2'd3;

    typedef struct packed {
        logic capture;
        logic search;
        logic update;
    } cmd_t;

endpackage

### hw/rtl/sorted_sparse_vector_accumulator.sv
// The result strobe (done) follows the SEARCH and UPDATE states after the accepting edge.
// A new item may be accepted in the UPDATE state of the last, at any fill level; search then update.
// The cell row compares all live entries at once, then shifts in one step.
// Reset clears the entry count and control; entry cells are not reset.
// Results are valid with done, which is high for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

// Sorted sparse vector: up to CAPACITY (index, value) pairs, ascending by
// signed index, each index unique.
//
// Per item:
//   accept edge  -> item captured, controller enters SEARCH (busy high)
//   SEARCH       -> every live cell compares its index against the key;
//                   the below-key prefix, match flag, matched value and
//                   positional read data are registered
//   UPDATE       -> sum, status, and one parallel cell move (shift up to
//                   open a slot, shift down to close one, or write value);
//                   a new item may be accepted on this cycle's closing edge
//   next cycle   -> done strobe with status/entry_total/read_* held stable
module sorted_sparse_vector_accumulator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  logic [2:0]          op,
    input  logic signed [31:0]  key_index,
    input  logic signed [31:0]  amount,
    input  logic [3:0]          position,
    output logic [1:0]          status,
    output logic [4:0]          entry_total,
    output logic signed [31:0]  read_index,
    output logic signed [31:0]  read_value
);

`include "sorted_sparse_vector_accumulator_assert.svh"

    ssva_pkg::cmd_t cmd;

    // sequencing: idle / search / update
    ssva_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // entry cells, compare row, update logic and result registers
    ssva_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .key_index   (key_index),
        .amount      (amount),
        .position    (position),
        .status      (status),
        .entry_total (entry_total),
        .read_index  (read_index),
        .read_value  (read_value)
    );

    // an accepted item always occupies the search cycle
    `SSVA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // search lasts exactly one cycle
    `SSVA_ASSERT_NXT(a_busy_single, busy, !busy)
    // an item is accepted no earlier than the update state of the last, so strobes never touch
    `SSVA_ASSERT_NXT(a_done_single, done, !done)
    // every strobe traces back to an accepted item, through the search and update states
    `SSVA_ASSERT_IMP(a_done_origin, done, $past(start && !busy, 3))

endmodule

### hw/rtl/ssva_ctrl.sv
`timescale 1ns / 1ps

module ssva_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output ssva_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = accept ? S_SEARCH : S_IDLE;
            S_SEARCH: state_next = S_UPDATE;
            S_UPDATE: state_next = accept ? S_SEARCH : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        busy_next = (state_next == S_SEARCH);
        done_next = (state_reg == S_UPDATE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign cmd.capture = accept;
    assign cmd.search  = (state_reg == S_SEARCH);
    assign cmd.update  = (state_reg == S_UPDATE);

endmodule

### hw/rtl/ssva_datapath.sv
`timescale 1ns / 1ps

module ssva_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ssva_pkg::cmd_t      cmd,
    input  logic [2:0]          op,
    input  logic signed [31:0]  key_index,
    input  logic signed [31:0]  amount,
    input  logic [3:0]          position,
    output logic [1:0]          status,
    output logic [4:0]          entry_total,
    output logic signed [31:0]  read_index,
    output logic signed [31:0]  read_value
);

    // entry cells, kept sorted by index; only the first count_reg are live
    logic signed [31:0] idx_reg  [ssva_pkg::CAPACITY];
    logic signed [31:0] val_reg  [ssva_pkg::CAPACITY];
    logic signed [31:0] idx_next [ssva_pkg::CAPACITY];
    logic signed [31:0] val_next [ssva_pkg::CAPACITY];
    logic [ssva_pkg::CNT_W-1:0] count_reg, count_next;

    // captured item
    logic [2:0]         op_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] amt_reg;
    logic [3:0]         pos_reg;

    // search results
    logic [ssva_pkg::CAPACITY-1:0] less_s, found_s, less_reg;
    logic               found_any_reg;
    logic signed [31:0] old_val_s, old_val_reg;
    logic signed [31:0] rd_idx_s, rd_val_s, rd_idx_reg, rd_val_reg;
    logic               rd_ok_s, rd_ok_reg;
    logic [ssva_pkg::CMP_W-1:0] pos_ext;

    // update
    logic [ssva_pkg::CAPACITY-1:0] ins_here;
    logic signed [31:0] sum;
    logic               full;
    logic               do_ins, do_rem, do_wr, do_clr;
    logic [1:0]         st_next;
    logic signed [31:0] out_idx_next, out_val_next;

    logic [1:0]         status_reg;
    logic [4:0]         total_reg;
    logic signed [31:0] out_idx_reg, out_val_reg;

    assign pos_ext = ssva_pkg::CMP_W'(pos_reg);

    // parallel compare in every live cell; less_s is a prefix of ones
    always_comb
    begin
        less_s    = '0;
        found_s   = '0;
        old_val_s = '0;
        rd_idx_s  = '0;
        rd_val_s  = '0;
        for (int i = 0; i < ssva_pkg::CAPACITY; i++)
        begin
            if (ssva_pkg::CNT_W'(i) < count_reg)
            begin
                less_s[i]  = idx_reg[i] < key_reg;
                found_s[i] = idx_reg[i] == key_reg;
            end
            if (found_s[i])
                old_val_s = val_reg[i];
            if (pos_ext == ssva_pkg::CMP_W'(i))
            begin
                rd_idx_s = idx_reg[i];
                rd_val_s = val_reg[i];
            end
        end
        rd_ok_s = pos_ext < ssva_pkg::CMP_W'(count_reg);
    end

    // first cell not below the key: insert slot, or the match if present
    assign ins_here = ~less_reg & {less_reg[ssva_pkg::CAPACITY-2:0], 1'b1};
    assign sum      = old_val_reg + amt_reg;
    assign full     = count_reg >= ssva_pkg::CNT_W'(ssva_pkg::CAPACITY);

    always_comb
    begin
        do_ins       = 1'b0;
        do_rem       = 1'b0;
        do_wr        = 1'b0;
        do_clr       = 1'b0;
        st_next      = ssva_pkg::ST_OK;
        out_idx_next = '0;
        out_val_next = '0;
        unique case (op_reg)
            ssva_pkg::OP_INSERT:
            begin
                if (!found_any_reg)
                begin
                    if (full)
                        st_next = ssva_pkg::ST_FULL;
                    else
                        do_ins = 1'b1;
                end
            end
            ssva_pkg::OP_ACCUM:
            begin
                if (found_any_reg)
                begin
                    if (sum == 32'sd0)
                    begin
                        do_rem  = 1'b1;
                        st_next = ssva_pkg::ST_REMOVED;
                    end
                    else
                        do_wr = 1'b1;
                end
                else if (full)
                    st_next = ssva_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ssva_pkg::OP_DELETE:
            begin
                if (found_any_reg)
                    do_rem = 1'b1;
                else
                    st_next = ssva_pkg::ST_MISSING;
            end
            ssva_pkg::OP_READ:
            begin
                if (rd_ok_reg)
                begin
                    out_idx_next = rd_idx_reg;
                    out_val_next = rd_val_reg;
                end
                else
                    st_next = ssva_pkg::ST_MISSING;
            end
            ssva_pkg::OP_CLEAR: do_clr = 1'b1;
            default: ;
        endcase

        priority if (do_clr)
            count_next = '0;
        else if (do_ins)
            count_next = count_reg + 1'b1;
        else if (do_rem)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    // each cell shifts up, shifts down, loads, or holds
    always_comb
    begin
        for (int i = 0; i < ssva_pkg::CAPACITY; i++)
        begin
            idx_next[i] = idx_reg[i];
            val_next[i] = val_reg[i];
            if (!less_reg[i])
            begin
                if (do_ins)
                begin
                    if (ins_here[i])
                    begin
                        idx_next[i] = key_reg;
                        val_next[i] = amt_reg;
                    end
                    else if (i > 0)
                    begin
                        idx_next[i] = idx_reg[(i > 0) ? i - 1 : 0];
                        val_next[i] = val_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                if (do_rem && (i < ssva_pkg::CAPACITY - 1))
                begin
                    idx_next[i] = idx_reg[(i < ssva_pkg::CAPACITY - 1) ? i + 1 : i];
                    val_next[i] = val_reg[(i < ssva_pkg::CAPACITY - 1) ? i + 1 : i];
                end
                if (do_wr && ins_here[i])
                    val_next[i] = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.update)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            key_reg <= key_index;
            amt_reg <= amount;
            pos_reg <= position;
        end
        if (cmd.search)
        begin
            less_reg      <= less_s;
            found_any_reg <= |found_s;
            old_val_reg   <= old_val_s;
            rd_ok_reg     <= rd_ok_s;
            rd_idx_reg    <= rd_idx_s;
            rd_val_reg    <= rd_val_s;
        end
        if (cmd.update)
        begin
            for (int i = 0; i < ssva_pkg::CAPACITY; i++)
            begin
                idx_reg[i] <= idx_next[i];
                val_reg[i] <= val_next[i];
            end
            status_reg  <= st_next;
            total_reg   <= 5'(ssva_pkg::TOT_W'(count_next));
            out_idx_reg <= out_idx_next;
            out_val_reg <= out_val_next;
        end
    end

    assign status      = status_reg;
    assign entry_total = total_reg;
    assign read_index  = out_idx_reg;
    assign read_value  = out_val_reg;

endmodule
